// ----- hdl/b2pd_pkg.sv -----
// Shared constants, types and functions of the packed decimal encoder.
`timescale 1ns / 1ps

package b2pd_pkg;

    localparam int VAL_W     = 64;
    localparam int NB_W      = 4;
    localparam int BYTE_W    = 8;
    localparam int MAX_BYTES = 8;
    localparam int MAX_DIG   = 2 * MAX_BYTES - 1;
    localparam int BCD_W     = 4 * MAX_DIG;
    localparam int FIELD_W   = BYTE_W * MAX_BYTES;

    localparam int MAG_RAW   = (MAX_DIG * 3322 + 999) / 1000;
    localparam int MAG_W     = (MAG_RAW > VAL_W) ? VAL_W : MAG_RAW;

    localparam int STEP_BITS = 8;
    localparam int STEPS     = (MAG_W + STEP_BITS - 1) / STEP_BITS;
    localparam int SH_W      = STEPS * STEP_BITS;
    localparam int STEP_CW   = $clog2(STEPS + 1);

    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int IDX_W     = $clog2(MAX_BYTES);

    localparam logic [CNT_W-1:0]   NB_ONE    = CNT_W'(1);
    localparam logic [CNT_W-1:0]   NB_MAX    = CNT_W'(MAX_BYTES);
    localparam logic [NB_W-1:0]    NB_IN_MAX = NB_W'(MAX_BYTES);
    localparam logic [STEP_CW-1:0] STEP_END  = STEP_CW'(STEPS);

    localparam logic [3:0] SIGN_NEG = 4'hD;
    localparam logic [3:0] SIGN_POS = 4'hC;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [CNT_W-1:0] nb;
        logic             neg;
        logic             err;
    } t_item;

    function automatic logic [VAL_W-1:0] pow10(input int k);
        logic [VAL_W-1:0] r;
        r = 64'd1;
        for (int i = 0; i < k; i++) begin
            r = r * 64'd10;
        end
        return r;
    endfunction

endpackage

// ----- hdl/binary_to_packed_decimal.sv -----
// Top level of the binary to packed decimal (COMP-3) encoder.
// Output: n bytes at one byte per cycle; the converter works on the next item while the
// emitter sends, and takes a load step plus seven shift-add-3 steps of eight bits each.
// An item that does not fit skips the conversion steps and yields one error result.
// Reset is synchronous and empties all stages; results are never held off.
`timescale 1ns / 1ps

module binary_to_packed_decimal (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [b2pd_pkg::VAL_W-1:0]  i_value,
    input  logic        [b2pd_pkg::NB_W-1:0]   i_byte_count,
    output logic                               o_strobe,
    output logic        [b2pd_pkg::BYTE_W-1:0] o_packed_byte,
    output logic                               o_too_large,
    output logic                               o_last
);

    b2pd_pkg::t_item w_push_item;
    b2pd_pkg::t_item w_pop_item;
    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_q_valid;

    b2pd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_value      (i_value),
        .i_byte_count (i_byte_count),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    b2pd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_pop_item)
    );

    b2pd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_item        (w_pop_item),
        .o_pop         (w_pop),
        .o_strobe      (o_strobe),
        .o_packed_byte (o_packed_byte),
        .o_too_large   (o_too_large),
        .o_last        (o_last)
    );

endmodule

// ----- hdl/b2pd_front.sv -----
// Front end: item intake, magnitude, length clamp and fit classification.
`timescale 1ns / 1ps

module b2pd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [b2pd_pkg::VAL_W-1:0]   i_value,
    input  logic        [b2pd_pkg::NB_W-1:0]    i_byte_count,
    input  logic                                i_full,
    output logic                                o_push,
    output b2pd_pkg::t_item                     o_item
);

    logic                               r_vld;
    logic [b2pd_pkg::VAL_W-1:0]         r_mag;
    logic                               r_neg;
    logic                               r_min;
    logic [b2pd_pkg::CNT_W-1:0]         r_nb;

    logic [b2pd_pkg::VAL_W-1:0]         n_mag;
    logic [b2pd_pkg::CNT_W-1:0]         n_nb;
    logic [b2pd_pkg::VAL_W-1:0]         w_raw;
    logic [b2pd_pkg::CNT_W-1:0]         w_nbm1;
    logic [b2pd_pkg::VAL_W-1:0]         w_lim [b2pd_pkg::MAX_BYTES];
    logic                               w_accept;

    for (genvar g = 0; g < b2pd_pkg::MAX_BYTES; g++) begin : g_lim
        assign w_lim[g] = b2pd_pkg::pow10(2 * g + 1);
    end

    assign w_raw    = $unsigned(i_value);
    assign o_busy   = r_vld && i_full;
    assign w_accept = i_start && !o_busy;
    assign o_push   = r_vld && !i_full;

    always_comb begin
        n_mag = w_raw[b2pd_pkg::VAL_W-1] ? (~w_raw + 64'd1) : w_raw;
        priority if (i_byte_count == '0) begin
            n_nb = b2pd_pkg::NB_ONE;
        end else if (i_byte_count > b2pd_pkg::NB_IN_MAX) begin
            n_nb = b2pd_pkg::NB_MAX;
        end else begin
            n_nb = i_byte_count[b2pd_pkg::CNT_W-1:0];
        end
    end

    assign w_nbm1 = r_nb - b2pd_pkg::NB_ONE;

    always_comb begin
        o_item.mag = r_mag[b2pd_pkg::MAG_W-1:0];
        o_item.nb  = r_nb;
        o_item.neg = r_neg;
        o_item.err = r_min || (r_mag >= w_lim[w_nbm1[b2pd_pkg::IDX_W-1:0]]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
        if (w_accept) begin
            r_mag <= n_mag;
            r_neg <= w_raw[b2pd_pkg::VAL_W-1];
            r_min <= (w_raw == {1'b1, {(b2pd_pkg::VAL_W-1){1'b0}}});
            r_nb  <= n_nb;
        end
    end

endmodule

// ----- hdl/b2pd_queue.sv -----
// Two-entry item queue between the front end and the back end.
`timescale 1ns / 1ps

module b2pd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b2pd_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output b2pd_pkg::t_item o_item
);

    b2pd_pkg::t_item r_slot [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (i_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

endmodule

// ----- hdl/b2pd_back.sv -----
// Back end: shift-add-3 decimal conversion and packed byte emission.
`timescale 1ns / 1ps

module b2pd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  b2pd_pkg::t_item                  i_item,
    output logic                             o_pop,
    output logic                             o_strobe,
    output logic [b2pd_pkg::BYTE_W-1:0]      o_packed_byte,
    output logic                             o_too_large,
    output logic                             o_last
);

    logic                              r_cv_vld;
    logic [b2pd_pkg::STEP_CW-1:0]      r_cv_cnt;
    logic [b2pd_pkg::SH_W-1:0]         r_sh;
    logic [b2pd_pkg::BCD_W-1:0]        r_bcd;
    logic [b2pd_pkg::CNT_W-1:0]        r_cv_nb;
    logic                              r_cv_neg;
    logic                              r_cv_err;

    logic                              r_em_vld;
    logic [b2pd_pkg::FIELD_W-1:0]      r_em_v;
    logic [b2pd_pkg::IDX_W-1:0]        r_em_ptr;
    logic [b2pd_pkg::CNT_W-1:0]        r_em_nb;
    logic                              r_em_err;

    logic [b2pd_pkg::SH_W-1:0]         n_sh;
    logic [b2pd_pkg::SH_W-1:0]         w_sh;
    logic [b2pd_pkg::BCD_W-1:0]        w_bcd;
    logic [b2pd_pkg::CNT_W-1:0]        w_nbm1;
    logic                              w_cv_ready;
    logic                              w_em_last;
    logic                              w_em_free;
    logic                              w_xfer;
    logic                              w_cv_free;

    assign w_cv_ready = r_cv_vld && (r_cv_cnt == b2pd_pkg::STEP_END);
    assign w_em_last  = r_em_vld && (r_em_err || (r_em_ptr == '0));
    assign w_em_free  = !r_em_vld || w_em_last;
    assign w_xfer     = w_cv_ready && w_em_free;
    assign w_cv_free  = !r_cv_vld || w_xfer;
    assign o_pop      = i_valid && w_cv_free;
    assign w_nbm1     = r_cv_nb - b2pd_pkg::NB_ONE;

    always_comb begin
        n_sh = '0;
        n_sh[b2pd_pkg::MAG_W-1:0] = i_item.mag;
    end

    always_comb begin
        w_bcd = r_bcd;
        w_sh  = r_sh;
        for (int b = 0; b < b2pd_pkg::STEP_BITS; b++) begin
            for (int d = 0; d < b2pd_pkg::MAX_DIG; d++) begin
                if (w_bcd[4*d +: 4] >= 4'd5) begin
                    w_bcd[4*d +: 4] = w_bcd[4*d +: 4] + 4'd3;
                end
            end
            w_bcd = {w_bcd[b2pd_pkg::BCD_W-2:0], w_sh[b2pd_pkg::SH_W-1]};
            w_sh  = {w_sh[b2pd_pkg::SH_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_vld <= 1'b0;
        end else if (o_pop) begin
            r_cv_vld <= 1'b1;
        end else if (w_xfer) begin
            r_cv_vld <= 1'b0;
        end
        if (o_pop) begin
            r_sh     <= n_sh;
            r_bcd    <= '0;
            r_cv_nb  <= i_item.nb;
            r_cv_neg <= i_item.neg;
            r_cv_err <= i_item.err;
            r_cv_cnt <= i_item.err ? b2pd_pkg::STEP_END : '0;
        end else if (r_cv_vld && !w_cv_ready) begin
            r_sh     <= w_sh;
            r_bcd    <= w_bcd;
            r_cv_cnt <= r_cv_cnt + b2pd_pkg::STEP_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_vld <= 1'b0;
        end else if (w_xfer) begin
            r_em_vld <= 1'b1;
        end else if (w_em_last) begin
            r_em_vld <= 1'b0;
        end
        if (w_xfer) begin
            r_em_v   <= {r_bcd, r_cv_neg ? b2pd_pkg::SIGN_NEG : b2pd_pkg::SIGN_POS};
            r_em_nb  <= r_cv_nb;
            r_em_err <= r_cv_err;
            r_em_ptr <= r_cv_err ? '0 : w_nbm1[b2pd_pkg::IDX_W-1:0];
        end else if (r_em_vld && !w_em_last) begin
            r_em_ptr <= r_em_ptr - b2pd_pkg::IDX_W'(1);
        end
    end

    assign o_strobe      = r_em_vld;
    assign o_too_large   = r_em_err;
    assign o_last        = w_em_last;
    assign o_packed_byte = r_em_err ? '0 : r_em_v[b2pd_pkg::BYTE_W*r_em_ptr +: b2pd_pkg::BYTE_W];

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_too_large |-> o_last)
        else $error("error result not marked last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_too_large |-> o_packed_byte == '0)
        else $error("error result carries a nonzero byte");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_em_vld |-> ({1'b0, r_em_ptr} < {1'b0, r_em_nb}))
        else $error("byte pointer outside the field");

    a_xfer_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer |=> r_em_vld && (r_em_ptr == $past(w_nbm1[b2pd_pkg::IDX_W-1:0])
                                || $past(r_cv_err)))
        else $error("handoff did not load the emitter");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv_vld |-> r_cv_cnt <= b2pd_pkg::STEP_END)
        else $error("conversion step count overran");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the binary to packed decimal (COMP-3) encoder.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [b2pd_pkg::BYTE_W-1:0] packed_byte;
        logic                        too_large;
        logic                        last;
    } t_comp3_res;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic signed [b2pd_pkg::VAL_W-1:0]  i_value;
    logic        [b2pd_pkg::NB_W-1:0]   i_byte_count;
    logic                               o_strobe;
    logic        [b2pd_pkg::BYTE_W-1:0] o_packed_byte;
    logic                               o_too_large;
    logic                               o_last;

    t_comp3_res pending_bytes[$];
    int         error_count = 0;
    bit         sender_idles = 1'b1;

    binary_to_packed_decimal u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_byte_count  (i_byte_count),
        .o_strobe      (o_strobe),
        .o_packed_byte (o_packed_byte),
        .o_too_large   (o_too_large),
        .o_last        (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int clamp_count(input logic [b2pd_pkg::NB_W-1:0] count);
        int n;
        n = int'(count);
        if (n < 1) n = 1;
        if (n > b2pd_pkg::MAX_BYTES) n = b2pd_pkg::MAX_BYTES;
        return n;
    endfunction

    function automatic logic [b2pd_pkg::VAL_W-1:0] digit_limit(input int n);
        logic [b2pd_pkg::VAL_W-1:0] lim;
        lim = 64'd1;
        for (int i = 0; i < 2 * n - 1; i++) lim = lim * 64'd10;
        return lim;
    endfunction

    function automatic void push_result(input logic [b2pd_pkg::BYTE_W-1:0] b,
                                        input logic err, input logic fin);
        t_comp3_res r;
        r.packed_byte = b;
        r.too_large   = err;
        r.last        = fin;
        pending_bytes.push_back(r);
    endfunction

    function automatic void encode_comp3(input logic [b2pd_pkg::VAL_W-1:0] value,
                                         input logic [b2pd_pkg::NB_W-1:0] count);
        int                         n;
        int                         nd;
        logic                       neg;
        logic [b2pd_pkg::VAL_W-1:0] mag;
        logic [3:0]                 dig [b2pd_pkg::MAX_DIG];
        n   = clamp_count(count);
        nd  = 2 * n - 1;
        neg = value[b2pd_pkg::VAL_W-1];
        if (value == {1'b1, {(b2pd_pkg::VAL_W-1){1'b0}}}) begin
            push_result('0, 1'b1, 1'b1);
            return;
        end
        mag = neg ? (~value + 64'd1) : value;
        for (int i = 0; i < nd; i++) begin
            dig[i] = 4'(mag % 64'd10);
            mag    = mag / 64'd10;
        end
        if (mag != 0) begin
            push_result('0, 1'b1, 1'b1);
            return;
        end
        for (int i = 0; i < n - 1; i++) begin
            push_result({dig[nd-1-2*i], dig[nd-2-2*i]}, 1'b0, 1'b0);
        end
        push_result({dig[0], neg ? b2pd_pkg::SIGN_NEG : b2pd_pkg::SIGN_POS}, 1'b0, 1'b1);
    endfunction

    task automatic send_item(input logic [b2pd_pkg::VAL_W-1:0] value,
                             input logic [b2pd_pkg::NB_W-1:0] count);
        while (sender_idles && $urandom_range(99) < 22) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_value      <= value;
        i_byte_count <= count;
        do @(posedge i_clk); while (busy !== 1'b0);
        encode_comp3(value, count);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [b2pd_pkg::VAL_W-1:0] pick_value(input int n);
        logic [b2pd_pkg::VAL_W-1:0] lim;
        logic [b2pd_pkg::VAL_W-1:0] mag;
        int                         mode;
        lim  = digit_limit(n);
        mode = $urandom_range(9);
        if (mode <= 5) begin
            mag = {$urandom, $urandom} % lim;
        end else if (mode == 6) begin
            mag = $urandom_range(1) ? lim : lim - 64'd1;
        end else if (mode == 7) begin
            return {$urandom, $urandom};
        end else begin
            mag = {$urandom, $urandom} >> $urandom_range(63);
        end
        return $urandom_range(1) ? (~mag + 64'd1) : mag;
    endfunction

    function automatic logic [b2pd_pkg::NB_W-1:0] pick_count();
        if ($urandom_range(99) < 85) begin
            return b2pd_pkg::NB_W'($urandom_range(1, b2pd_pkg::MAX_BYTES));
        end
        return b2pd_pkg::NB_W'($urandom_range(0, 15));
    endfunction

    task automatic test_directed();
        for (int n = 1; n <= b2pd_pkg::MAX_BYTES; n++) send_item(64'd0, b2pd_pkg::NB_W'(n));
        send_item(64'h7FFF_FFFF_FFFF_FFFF, b2pd_pkg::NB_IN_MAX);
        send_item(64'h8000_0000_0000_0000, b2pd_pkg::NB_IN_MAX);
        send_item(64'd999_999_999_999_999, b2pd_pkg::NB_IN_MAX);
        send_item(64'd1_000_000_000_000_000, b2pd_pkg::NB_IN_MAX);
        send_item(-64'sd999_999_999_999_999, b2pd_pkg::NB_IN_MAX);
        send_item(-64'sd1, 4'd1);
        send_item(64'd9, 4'd1);
        send_item(64'd10, 4'd1);
        send_item(-64'sd7, 4'd0);
        send_item(64'd12345, 4'd15);
        send_item(-64'sd1234567, 4'd9);
        send_item(64'd1234567, 4'd4);
        send_item(-64'sd12345678, 4'd4);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd1);
    endtask

    task automatic test_random(input int count);
        logic [b2pd_pkg::NB_W-1:0] nb;
        for (int k = 0; k < count; k++) begin
            nb = pick_count();
            send_item(pick_value(clamp_count(nb)), nb);
        end
    endtask

    task automatic test_back_to_back(input int count);
        sender_idles = 1'b0;
        test_random(count);
        sender_idles = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_comp3_res exp_r;
        if (i_rst_n === 1'b1) begin
            if (o_strobe !== 1'b0 && o_strobe !== 1'b1) begin
                $display("%0t: strobe unknown: %b", $time, o_strobe);
                error_count++;
            end else if (o_strobe) begin
                if (pending_bytes.size() == 0) begin
                    $display("%0t: unexpected result byte=%h too_large=%b last=%b",
                             $time, o_packed_byte, o_too_large, o_last);
                    error_count++;
                end else begin
                    exp_r = pending_bytes.pop_front();
                    if (o_packed_byte !== exp_r.packed_byte) begin
                        $display("%0t: packed_byte expected %h actual %h",
                                 $time, exp_r.packed_byte, o_packed_byte);
                        error_count++;
                    end
                    if (o_too_large !== exp_r.too_large) begin
                        $display("%0t: too_large expected %b actual %b",
                                 $time, exp_r.too_large, o_too_large);
                        error_count++;
                    end
                    if (o_last !== exp_r.last) begin
                        $display("%0t: last expected %b actual %b",
                                 $time, exp_r.last, o_last);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_value      <= '0;
        i_byte_count <= 4'd1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(250);
        wait_drained();
        test_back_to_back(80);
        test_random(70);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_bytes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
